// File: design/soil_moisture_conditioner_unit_macros.svh
// ------------------------------------------------------------------------
// soil moisture conditioner assertion macros
// shared assertion shorthands, sampled on clk and disabled during reset
// ------------------------------------------------------------------------
`ifndef SOIL_MOISTURE_CONDITIONER_UNIT_MACROS_SVH
`define SOIL_MOISTURE_CONDITIONER_UNIT_MACROS_SVH

// same-cycle implication
`define SMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/smc_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// smc_pkg
// types and constants of the soil moisture conditioner
// ------------------------------------------------------------------------
package smc_pkg;

    // field widths
    localparam int RAW_W  = 12;
    localparam int TEMP_W = 12;
    localparam int PCT_W  = 14;

    // shared divider geometry
    localparam int DIV_W  = 32;
    localparam int DVS_W  = 16;
    localparam int PAIR_W = 5;

    // divider pass length of the slope division in quotient bit pairs
    localparam logic [PAIR_W-1:0] LIN_PAIRS = 5'd13;

    // reciprocals for the constant divisions of the correction
    // ceil(2^26 / 10), exact for magnitudes below 2^26 / 6
    localparam logic [22:0] REC10_MUL  = 23'd6710887;
    // ceil(2^38 / 625), exact for every 28-bit value
    localparam logic [28:0] REC625_MUL = 29'd439804652;

    // percent scale
    localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;

    // register map, index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_RAW_DRY     = 3'd0,
        REG_RAW_WET     = 3'd1,
        REG_TEMP_REF    = 3'd2,
        REG_TEMP_GAIN   = 3'd3,
        REG_TEMP_OFFSET = 3'd4,
        REG_DEC_PLACES  = 3'd5,
        REG_CORR_EN     = 3'd6
    } cfg_reg_t;

    // rounding codes
    localparam logic [1:0] DP_WHOLE  = 2'd0;
    localparam logic [1:0] DP_TENTH  = 2'd1;
    localparam logic [1:0] DP_NONE   = 2'd2;
    localparam logic [1:0] DP_UNUSED = 2'd3;

    typedef struct packed {
        logic        [RAW_W-1:0]  raw_sample;
        logic signed [TEMP_W-1:0] temperature_x10;
    } in_item_t;

    typedef struct packed {
        logic [RAW_W-1:0] filtered_raw;
        logic [PCT_W-1:0] moisture_x100;
        logic [PCT_W-1:0] temp_comp_x100;
    } out_item_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [PAIR_W-1:0] pairs;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: design/smc_div.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// smc_div
// shared restoring divider, two quotient bits per cycle; the dividend is
// left aligned so that a pass of n pairs leaves the quotient in acc[2n-1:0]
// ------------------------------------------------------------------------
module smc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  smc_pkg::div_req_t req,
    output smc_pkg::div_rsp_t rsp
);
    import smc_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [PAIR_W-1:0]       cnt_reg, cnt_next;
    logic [DIV_W-1:0]        acc_reg, acc_next;
    logic [DVS_W-1:0]        rem_reg, rem_next;
    logic [DVS_W-1:0]        dvs_reg, dvs_next;
    logic [DVS_W+DIV_W-1:0]  step1, step2;

    // one restoring step: shift in a dividend bit, subtract if it fits
    function automatic logic [DVS_W+DIV_W-1:0] div_step(
        input logic [DVS_W-1:0] rem,
        input logic [DIV_W-1:0] acc,
        input logic [DVS_W-1:0] dvs
    );
        logic [DVS_W:0] trial;
        logic           qbit;
        trial = {rem, acc[DIV_W-1]};
        qbit  = 1'b0;
        if (trial >= {1'b0, dvs})
        begin
            trial = trial - {1'b0, dvs};
            qbit  = 1'b1;
        end
        return {trial[DVS_W-1:0], acc[DIV_W-2:0], qbit};
    endfunction

    assign step1 = div_step(rem_reg, acc_reg, dvs_reg);
    assign step2 = div_step(step1[DVS_W+DIV_W-1:DIV_W], step1[DIV_W-1:0], dvs_reg);

    // control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.pairs;
            acc_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = step2[DVS_W+DIV_W-1:DIV_W];
            acc_next = step2[DIV_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == PAIR_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = acc_reg;

endmodule

// File: design/soil_moisture_conditioner_unit.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// soil_moisture_conditioner_unit
// moving average of probe samples with linear calibration and optional
// temperature correction
// ------------------------------------------------------------------------
// One sample is taken at a time and gives one result. The last WINDOW
// samples sit in a single-port ring memory with a registered read; the slot
// being overwritten is read, the running sum is updated and the new sample
// is written back in the next cycle. Entries not yet written count as zero
// through the fill count, so no clearing pass follows reset. The two
// divisions by a varying divisor (window average and calibration slope) go
// through one shared divider that retires two quotient bits a cycle, and
// that divider sets most of the cost; the divisions by ten and by 10000 in
// the temperature correction are reciprocal multiplies. A finished result
// waits in the output register while the next sample is taken; a result
// still stalled there holds the sequencer in its output step.
`include "soil_moisture_conditioner_unit_macros.svh"

module soil_moisture_conditioner_unit #(
    parameter int WINDOW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // sample channel
    input  logic                in_valid,
    output logic                in_stall,
    input  smc_pkg::in_item_t   in_data,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output smc_pkg::out_item_t  out_data
);
    import smc_pkg::*;

    localparam int PW         = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW         = $clog2(WINDOW + 1);
    localparam int SW         = RAW_W + $clog2(WINDOW);
    localparam int AVG_PAIRS  = (SW + 1) / 2;
    localparam int AVG_SHIFT  = DIV_W - 2 * AVG_PAIRS;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_RD   = 14'b00000000000010,
        S_ACC  = 14'b00000000000100,
        S_AVGW = 14'b00000000001000,
        S_LIN  = 14'b00000000010000,
        S_LINW = 14'b00000000100000,
        S_RND1 = 14'b00000001000000,
        S_SCL  = 14'b00000010000000,
        S_SCLW = 14'b00000100000000,
        S_MUL  = 14'b00001000000000,
        S_CORW = 14'b00010000000000,
        S_CLMP = 14'b00100000000000,
        S_RND2 = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } state_t;

    // configuration registers
    logic        [RAW_W-1:0]  raw_dry_reg;
    logic        [RAW_W-1:0]  raw_wet_reg;
    logic signed [TEMP_W-1:0] temp_ref_reg;
    logic signed [10:0]       temp_gain_reg;
    logic signed [14:0]       temp_offset_reg;
    logic        [1:0]        dec_places_reg;
    logic                     corr_en_reg;
    logic                     cfg_write;

    // control and datapath
    state_t                   state_reg, state_next;
    logic        [PW-1:0]     pos_reg, pos_next;
    logic        [FW-1:0]     fill_reg, fill_next;
    logic        [SW-1:0]     sum_reg, sum_next;
    logic        [RAW_W-1:0]  raw_reg, raw_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic        [RAW_W-1:0]  avg_reg, avg_next;
    logic        [PCT_W-1:0]  lin_reg, lin_next;
    logic        [PCT_W-1:0]  moist_reg, moist_next;
    logic        [PCT_W-1:0]  corr_reg, corr_next;
    logic                     neg_reg, neg_next;
    logic        [22:0]       gmag_reg, gmag_next;
    logic        [18:0]       scale_reg, scale_next;
    logic        [31:0]       cdiv_reg, cdiv_next;
    logic        [18:0]       cq_reg, cq_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_item_reg, out_item_next;

    // ring memory
    logic        [RAW_W-1:0]  ring_mem [WINDOW];
    logic        [RAW_W-1:0]  ring_rdata_reg;
    logic                     ring_we;

    // shared divider
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    // helper values
    logic        [RAW_W-1:0]  old_sample;
    logic        [SW-1:0]     sum_upd;
    logic                     wet_above;
    logic                     lin_zero, lin_full;
    logic        [RAW_W-1:0]  lin_num, lin_den;
    logic        [25:0]       lin_prod;
    logic signed [12:0]       temp_delta;
    logic signed [23:0]       gain_prod;
    logic        [23:0]       gain_mag;
    logic        [45:0]       scl_prod;
    logic        [18:0]       scl_q;
    logic signed [20:0]       scale_s;
    logic        [32:0]       corr_prod;
    logic        [31:0]       corr_dividend;
    logic        [56:0]       cq_prod;
    logic signed [20:0]       corr_sum;
    logic        [PCT_W-1:0]  rnd_in, rnd_out;

    // rounding to whole percent, tenths or none; reciprocal multiply is
    // exact for every input below 2^15
    function automatic logic [PCT_W-1:0] round_pct(
        input logic [PCT_W-1:0] p,
        input logic [1:0]       dp
    );
        logic [14:0] x100, x10;
        logic [27:0] p100;
        logic [30:0] p10;
        logic [8:0]  q100;
        logic [11:0] q10;
        logic [15:0] r100, r10;
        logic [PCT_W-1:0] res;
        x100 = {1'b0, p} + 15'd50;
        x10  = {1'b0, p} + 15'd5;
        p100 = {13'b0, x100} * 28'd5243;
        p10  = {16'b0, x10} * 31'd52429;
        q100 = p100[27:19];
        q10  = p10[30:19];
        r100 = (16'(q100) << 6) + (16'(q100) << 5) + (16'(q100) << 2);
        r10  = (16'(q10) << 3) + (16'(q10) << 1);
        case (dp)
            DP_WHOLE: res = r100[PCT_W-1:0];
            DP_TENTH: res = r10[PCT_W-1:0];
            default:  res = p;
        endcase
        return res;
    endfunction

    // configuration write and read back
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_dry_reg     <= 12'd2600;
            raw_wet_reg     <= 12'd1000;
            temp_ref_reg    <= 12'sd250;
            temp_gain_reg   <= '0;
            temp_offset_reg <= '0;
            dec_places_reg  <= DP_TENTH;
            corr_en_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(paddr[4:2]))
                REG_RAW_DRY:     raw_dry_reg     <= pwdata[11:0];
                REG_RAW_WET:     raw_wet_reg     <= pwdata[11:0];
                REG_TEMP_REF:    temp_ref_reg    <= pwdata[11:0];
                REG_TEMP_GAIN:   temp_gain_reg   <= pwdata[10:0];
                REG_TEMP_OFFSET: temp_offset_reg <= pwdata[14:0];
                REG_DEC_PLACES:  dec_places_reg  <= pwdata[1:0];
                REG_CORR_EN:     corr_en_reg     <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_reg_t'(paddr[4:2]))
            REG_RAW_DRY:     prdata = {20'b0, raw_dry_reg};
            REG_RAW_WET:     prdata = {20'b0, raw_wet_reg};
            REG_TEMP_REF:    prdata = 32'(temp_ref_reg);
            REG_TEMP_GAIN:   prdata = 32'(temp_gain_reg);
            REG_TEMP_OFFSET: prdata = 32'(temp_offset_reg);
            REG_DEC_PLACES:  prdata = {30'b0, dec_places_reg};
            REG_CORR_EN:     prdata = {31'b0, corr_en_reg};
            default:         prdata = '0;
        endcase
    end

    // ring memory, read of the slot about to be replaced
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[pos_reg] <= raw_reg;
        end
        ring_rdata_reg <= ring_mem[pos_reg];
    end

    // window update: slots past the fill count hold zero
    assign old_sample = (fill_reg == FW'(WINDOW)) ? ring_rdata_reg : '0;
    assign sum_upd    = sum_reg - SW'(old_sample) + SW'(raw_reg);

    // calibration clamps and slope numerator
    assign wet_above = raw_wet_reg > raw_dry_reg;
    assign lin_zero  = wet_above ? (avg_reg <= raw_dry_reg) : (avg_reg >= raw_dry_reg);
    assign lin_full  = wet_above ? (avg_reg >= raw_wet_reg) : (avg_reg <= raw_wet_reg);
    assign lin_num   = wet_above ? (avg_reg - raw_dry_reg) : (raw_dry_reg - avg_reg);
    assign lin_den   = wet_above ? (raw_wet_reg - raw_dry_reg) : (raw_dry_reg - raw_wet_reg);
    assign lin_prod  = {14'b0, lin_num} * 26'd10000;

    // temperature scale term, magnitude divided by ten so it truncates toward zero
    assign temp_delta = 13'(temp_reg) - 13'(temp_ref_reg);
    assign gain_prod  = temp_delta * temp_gain_reg;
    assign gain_mag   = gain_prod[23] ? 24'(-gain_prod) : 24'(gain_prod);
    assign scl_prod   = 46'(gmag_reg) * 46'(REC10_MUL);
    assign scl_q      = scl_prod[44:26];
    assign scale_s    = 21'sd10000 + (neg_reg ? -$signed({2'b0, scl_q}) : $signed({2'b0, scl_q}));

    // corrected product with half-unit bias, divided by 10000 as /16 then /625
    assign corr_prod     = {19'b0, moist_reg} * {14'b0, scale_reg};
    assign corr_dividend = corr_prod[31:0] + 32'd5000;
    assign cq_prod       = 57'(cdiv_reg[31:4]) * 57'(REC625_MUL);
    assign corr_sum      = $signed({2'b0, cq_reg}) + 21'(temp_offset_reg);

    // shared rounding stage
    assign rnd_in  = (state_reg == S_RND1) ? lin_reg : corr_reg;
    assign rnd_out = round_pct(rnd_in, dec_places_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        raw_next       = raw_reg;
        temp_next      = temp_reg;
        avg_next       = avg_reg;
        lin_next       = lin_reg;
        moist_next     = moist_reg;
        corr_next      = corr_reg;
        neg_next       = neg_reg;
        gmag_next      = gmag_reg;
        scale_next     = scale_reg;
        cdiv_next      = cdiv_reg;
        cq_next        = cq_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;
        ring_we        = 1'b0;
        div_req        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    raw_next   = in_data.raw_sample;
                    temp_next  = in_data.temperature_x10;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                ring_we  = 1'b1;
                sum_next = sum_upd;
                pos_next = (pos_reg == PW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                if (fill_reg != FW'(WINDOW))
                begin
                    fill_next = fill_reg + 1'b1;
                end
                div_req.start    = 1'b1;
                div_req.pairs    = PAIR_W'(AVG_PAIRS);
                div_req.dividend = DIV_W'(sum_upd) << AVG_SHIFT;
                div_req.divisor  = DVS_W'(fill_next);
                state_next       = S_AVGW;
            end
            S_AVGW:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[RAW_W-1:0];
                    state_next = S_LIN;
                end
            end
            S_LIN:
            begin
                if (lin_zero)
                begin
                    lin_next   = '0;
                    state_next = S_RND1;
                end
                else if (lin_full)
                begin
                    lin_next   = PCT_FULL;
                    state_next = S_RND1;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.pairs    = LIN_PAIRS;
                    div_req.dividend = DIV_W'(lin_prod) << 6;
                    div_req.divisor  = DVS_W'(lin_den);
                    state_next       = S_LINW;
                end
            end
            S_LINW:
            begin
                if (div_rsp.done)
                begin
                    lin_next   = div_rsp.quotient[PCT_W-1:0];
                    state_next = S_RND1;
                end
            end
            S_RND1:
            begin
                moist_next = rnd_out;
                state_next = S_SCL;
            end
            S_SCL:
            begin
                if (!corr_en_reg)
                begin
                    corr_next  = moist_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    neg_next   = gain_prod[23];
                    gmag_next  = gain_mag[22:0];
                    state_next = S_SCLW;
                end
            end
            S_SCLW:
            begin
                scale_next = scale_s[20] ? '0 : scale_s[18:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cdiv_next  = corr_dividend;
                state_next = S_CORW;
            end
            S_CORW:
            begin
                cq_next    = cq_prod[56:38];
                state_next = S_CLMP;
            end
            S_CLMP:
            begin
                if (corr_sum < 0)
                begin
                    corr_next = '0;
                end
                else if (corr_sum > 21'sd10000)
                begin
                    corr_next = PCT_FULL;
                end
                else
                begin
                    corr_next = corr_sum[PCT_W-1:0];
                end
                state_next = S_RND2;
            end
            S_RND2:
            begin
                corr_next  = rnd_out;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.filtered_raw   = avg_reg;
                    out_item_next.moisture_x100  = moist_reg;
                    out_item_next.temp_comp_x100 = corr_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        raw_reg      <= raw_next;
        temp_reg     <= temp_next;
        avg_reg      <= avg_next;
        lin_reg      <= lin_next;
        moist_reg    <= moist_next;
        corr_reg     <= corr_next;
        neg_reg      <= neg_next;
        gmag_reg     <= gmag_next;
        scale_reg    <= scale_next;
        cdiv_reg     <= cdiv_next;
        cq_reg       <= cq_next;
        out_item_reg <= out_item_next;
    end

    smc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ports
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // checks
    `SMC_ASSERT_IMP(a_div_done_in_wait, div_rsp.done, state_reg == S_AVGW || state_reg == S_LINW, "divider result outside a wait state")
    `SMC_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider started while busy")
    `SMC_ASSERT_IMP(a_sum_bound, 1'b1, (32'(sum_reg) <= (32'(fill_reg) * 32'd4095)), "running sum exceeds filled window")
    `SMC_ASSERT_NXT(a_ring_write_fills, state_reg == S_ACC, fill_reg != '0, "fill count empty after a ring write")
    `SMC_ASSERT_IMP(a_result_from_out, $rose(out_valid_reg), $past(state_reg == S_OUT), "result raised outside the output step")

endmodule
